// ===== src/lstk_pkg.sv =====
package lstk_pkg;

    // widths of the port fields, fixed by the interface
    localparam int unsigned PORT_DATA_W = 32;
    localparam int unsigned OPCODE_W    = 3;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned INDEX_W     = 6;
    localparam int unsigned CAP_W       = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef logic [OPCODE_W-1:0] opcode_t;

    localparam opcode_t OP_PUSH   = 3'd0;
    localparam opcode_t OP_POP    = 3'd1;
    localparam opcode_t OP_PEEK   = 3'd2;
    localparam opcode_t OP_CLEAR  = 3'd3;
    localparam opcode_t OP_SEARCH = 3'd4;

    // sequencer status seen by the top level
    typedef struct packed {
        logic idle;
        logic scan;
        logic done;
    } seq_stat_t;

endpackage

// ===== src/lstk_ram.sv =====
module lstk_ram #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0]    rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/lstk_seq.sv =====
module lstk_seq #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [$clog2(DEPTH+1)-1:0]              cap_eff,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [lstk_pkg::OPCODE_W-1:0]           s_opcode,
    input  logic signed [lstk_pkg::PORT_DATA_W-1:0] s_data_in,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_status,
    output logic signed [lstk_pkg::PORT_DATA_W-1:0] m_data_out,
    output logic                                    m_found,
    output logic [lstk_pkg::INDEX_W-1:0]            m_found_index,
    output logic [lstk_pkg::COUNT_W-1:0]            m_count,
    output logic                                    m_is_empty,
    output logic                                    m_is_full,
    output logic                                    ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]                ram_wr_addr,
    output logic [DATA_WIDTH-1:0]                   ram_wr_data,
    output logic                                    ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]                ram_rd_addr,
    input  logic [DATA_WIDTH-1:0]                   ram_rd_data,
    output lstk_pkg::seq_stat_t                     stat
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic                  res_status_reg, res_status_next;
    logic [DATA_WIDTH-1:0] res_dout_reg, res_dout_next;
    logic                  res_found_reg, res_found_next;
    logic [AW-1:0]         res_fidx_reg, res_fidx_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_status_reg;
    logic [DATA_WIDTH-1:0] m_dout_reg;
    logic                  m_found_reg;
    logic [AW-1:0]         m_fidx_reg;
    logic [CW-1:0]         m_cnt_reg;
    logic                  m_empty_reg;
    logic                  m_full_reg;

    logic                  accept;
    logic                  out_load;
    logic                  hit;
    logic [DATA_WIDTH-1:0] data_in_w;

    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign hit       = (ram_rd_data == key_reg);
    assign data_in_w = DATA_WIDTH'($unsigned(s_data_in));

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_dout_next   = res_dout_reg;
        res_found_next  = res_found_reg;
        res_fidx_next   = res_fidx_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = cnt_reg[AW-1:0];
        ram_wr_data     = data_in_w;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = idx_reg - AW'(1);

        case (state_reg)
            ST_IDLE: begin
                ram_rd_addr = cnt_reg[AW-1:0] - AW'(1);
                if (accept) begin
                    res_status_next = 1'b0;
                    res_dout_next   = '0;
                    res_found_next  = 1'b0;
                    res_fidx_next   = '0;
                    key_next        = data_in_w;
                    idx_next        = cnt_reg[AW-1:0] - AW'(1);
                    state_next      = ST_DONE;
                    case (s_opcode)
                        lstk_pkg::OP_PUSH: begin
                            if (cnt_reg >= cap_eff) begin
                                res_status_next = 1'b1;
                            end else begin
                                ram_wr_en = 1'b1;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        lstk_pkg::OP_POP: begin
                            if (cnt_reg == '0) begin
                                res_status_next = 1'b1;
                            end else begin
                                ram_rd_en  = 1'b1;
                                cnt_next   = cnt_reg - CW'(1);
                                state_next = ST_READ;
                            end
                        end
                        lstk_pkg::OP_PEEK: begin
                            if (cnt_reg == '0) begin
                                res_status_next = 1'b1;
                            end else begin
                                ram_rd_en  = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        lstk_pkg::OP_CLEAR: begin
                            cnt_next = '0;
                        end
                        lstk_pkg::OP_SEARCH: begin
                            if (cnt_reg != '0) begin
                                ram_rd_en  = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_dout_next = ram_rd_data;
                state_next    = ST_DONE;
            end
            ST_SCAN: begin
                // read data belongs to idx_reg; walk toward the bottom
                if (hit) begin
                    res_found_next = 1'b1;
                    res_fidx_next  = idx_reg;
                    state_next     = ST_DONE;
                end else if (idx_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    ram_rd_en = 1'b1;
                    idx_next  = idx_reg - AW'(1);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_dout_reg   <= res_dout_next;
        res_found_reg  <= res_found_next;
        res_fidx_reg   <= res_fidx_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_dout_reg   <= res_dout_reg;
            m_found_reg  <= res_found_reg;
            m_fidx_reg   <= res_fidx_reg;
            m_cnt_reg    <= cnt_reg;
            m_empty_reg  <= (cnt_reg == '0);
            m_full_reg   <= (cnt_reg >= cap_eff);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_data_out    = lstk_pkg::PORT_DATA_W'(m_dout_reg);
    assign m_found       = m_found_reg;
    assign m_found_index = lstk_pkg::INDEX_W'(m_fidx_reg);
    assign m_count       = lstk_pkg::COUNT_W'(m_cnt_reg);
    assign m_is_empty    = m_empty_reg;
    assign m_is_full     = m_full_reg;

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.scan = (state_reg == ST_SCAN);
    assign stat.done = (state_reg == ST_DONE);

endmodule

// ===== src/bounded_lifo_stack_with_search_unit.sv =====
// Bounded LIFO stack of DATA_WIDTH-bit words held in a single-port-read
// memory, with push, pop, peek, clear and a top-down key search. One
// transaction is worked on at a time; each yields one result. The result
// register is loaded from the done state, which push, clear and unknown
// opcodes enter straight from idle, pop and peek through a read state
// (one registered memory read), and search through a scan state, where the
// memory read port and the key comparator visit one entry per cycle from
// the top down. s_ready returns as that load is made. The load waits while
// the output register still holds a result that m_ready has not taken. The
// capacity register resets to 64 and a value above DEPTH acts as DEPTH;
// write it only while the block is idle.
module bounded_lifo_stack_with_search_unit #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lstk_pkg::CAP_W-1:0]              cfg_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [lstk_pkg::OPCODE_W-1:0]           s_opcode,
    input  logic signed [lstk_pkg::PORT_DATA_W-1:0] s_data_in,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_status,
    output logic signed [lstk_pkg::PORT_DATA_W-1:0] m_data_out,
    output logic                                    m_found,
    output logic [lstk_pkg::INDEX_W-1:0]            m_found_index,
    output logic [lstk_pkg::COUNT_W-1:0]            m_count,
    output logic                                    m_is_empty,
    output logic                                    m_is_full
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);

    logic [lstk_pkg::CAP_W-1:0] cap_reg;
    logic [CW-1:0]              cap_eff;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;
    lstk_pkg::seq_stat_t   stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lstk_pkg::CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // capacity saturates at the memory depth
    assign cap_eff = (32'(cap_reg) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(cap_reg);

    lstk_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lstk_seq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cap_eff       (cap_eff),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_data_in     (s_data_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_data_out    (m_data_out),
        .m_found       (m_found),
        .m_found_index (m_found_index),
        .m_count       (m_count),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data),
        .stat          (stat)
    );

    // a transaction is only taken by an idle sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> stat.idle)
        else $error("input taken while sequencer busy");

    // memory is written only on acceptance of a push
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (s_valid && s_ready && s_opcode == lstk_pkg::OP_PUSH))
        else $error("memory write outside a push");

    // no write while a scan runs or a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.scan || stat.done) |-> !ram_wr_en)
        else $error("memory write while busy");

    // a failed operation returns no data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_data_out == '0 && !m_found))
        else $error("failed result carries data");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_found_index == '0))
        else $error("index set without a match");

endmodule
